// ===== hw/rtl/rls_pkg.sv =====
// Shared types and constants for the radix literal scanner.
`default_nettype none

package rls_pkg;

    // Width of the value accumulator; results are zero-extended to 64 bits.
    localparam int VALUE_BITS  = 64;
    // Width of the saturating length counter; results carry its low 16 bits.
    localparam int LENGTH_BITS = 16;

    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};

    // Characters that steer the scan.
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_SEVEN = 8'h37;  // '7'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UP_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UP_B  = 8'h42;  // 'B'
    localparam logic [7:0] CH_UP_D  = 8'h44;  // 'D'
    localparam logic [7:0] CH_UP_F  = 8'h46;  // 'F'
    localparam logic [7:0] CH_UP_H  = 8'h48;  // 'H'
    localparam logic [7:0] CH_UP_O  = 8'h4F;  // 'O'
    localparam logic [7:0] CH_UP_X  = 8'h58;  // 'X'
    localparam logic [7:0] CH_LO_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LO_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_DQUOTE = 8'h22; // '"'
    localparam logic [7:0] CH_SQUOTE = 8'h27; // '\''
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CASE_BIT = 8'h20;  // lower case = upper case + 0x20

    typedef enum logic [9:0] {
        MODE_IDLE     = 10'b00_0000_0001,
        MODE_AMP      = 10'b00_0000_0010,
        MODE_ZERO     = 10'b00_0000_0100,
        MODE_HEX      = 10'b00_0000_1000,
        MODE_OCT      = 10'b00_0001_0000,
        MODE_BIN      = 10'b00_0010_0000,
        MODE_DEC      = 10'b00_0100_0000,
        MODE_CHR      = 10'b00_1000_0000,
        MODE_CHRQ     = 10'b01_0000_0000,
        MODE_CHRCLOSE = 10'b10_0000_0000
    } scan_mode_t;

    typedef struct packed {
        scan_mode_t             mode;
        logic [VALUE_BITS-1:0]  acc;
        logic [LENGTH_BITS-1:0] len;
        logic                   seen;
        logic [7:0]             quote;
    } scan_state_t;

    typedef struct packed {
        logic        included;
        logic [15:0] count;
        logic [63:0] value;
        logic        matched;
    } scan_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rls_step.sv =====
// Next-state and result logic of the scanner for one text byte.
`default_nettype none

module rls_step (
    input  wire logic [7:0]            text_byte,
    input  wire logic                  first,
    input  wire rls_pkg::scan_state_t  state_cur,
    output rls_pkg::scan_state_t       state_nxt,
    output logic                       emit,
    output rls_pkg::scan_result_t      result
);
    import rls_pkg::*;

    // Value of a character as a hex-style digit, with a flag for "is a digit at all".
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'h10;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = {1'b0, c[3:0]};
        else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F))
            d = {1'b0, 4'(c[2:0] + 3'd1) + 4'd8};
        return d;
    endfunction

    function automatic logic is_letter(input logic [7:0] c, input logic [7:0] upper);
        return (c == upper) || (c == (upper | CASE_BIT));
    endfunction

    logic [4:0]             dig;
    logic                   dig_ok;
    logic [VALUE_BITS-1:0]  acc_scaled;
    logic [LENGTH_BITS-1:0] len_inc;

    assign dig     = hex_digit(text_byte);
    assign len_inc = (state_cur.len == LENGTH_MAX) ? LENGTH_MAX : state_cur.len + 1'b1;

    always_comb
    begin
        dig_ok     = 1'b0;
        acc_scaled = state_cur.acc;
        case (state_cur.mode)
            MODE_HEX:
            begin
                dig_ok     = !dig[4];
                acc_scaled = state_cur.acc << 4;
            end
            MODE_OCT:
            begin
                dig_ok     = !dig[4] && !dig[3];
                acc_scaled = state_cur.acc << 3;
            end
            MODE_BIN:
            begin
                dig_ok     = !dig[4] && (dig[3:1] == 3'd0);
                acc_scaled = state_cur.acc << 1;
            end
            MODE_DEC:
            begin
                dig_ok     = !dig[4] && (dig[3:0] <= 4'd9);
                acc_scaled = (state_cur.acc << 3) + (state_cur.acc << 1);
            end
            default:
            begin
                dig_ok     = 1'b0;
                acc_scaled = state_cur.acc;
            end
        endcase
    end

    always_comb
    begin
        state_nxt = state_cur;
        emit      = 1'b0;
        result    = '0;

        if (first)
        begin
            state_nxt.acc   = '0;
            state_nxt.len   = '0;
            state_nxt.seen  = 1'b0;
            state_nxt.quote = '0;
            if (text_byte == CH_AMP)
            begin
                state_nxt.mode = MODE_AMP;
                state_nxt.len  = LENGTH_BITS'(1);
            end
            else if (text_byte == CH_ZERO)
            begin
                state_nxt.mode = MODE_ZERO;
                state_nxt.len  = LENGTH_BITS'(1);
            end
            else
            begin
                state_nxt.mode = MODE_IDLE;
                emit           = 1'b1;
            end
        end
        else
        begin
            case (state_cur.mode)
                MODE_AMP, MODE_ZERO:
                begin
                    state_nxt.len = len_inc;
                    if (is_letter(text_byte, CH_UP_H) && state_cur.mode == MODE_AMP)
                        state_nxt.mode = MODE_HEX;
                    else if (is_letter(text_byte, CH_UP_X) && state_cur.mode == MODE_ZERO)
                        state_nxt.mode = MODE_HEX;
                    else if (is_letter(text_byte, CH_UP_O))
                        state_nxt.mode = MODE_OCT;
                    else if (is_letter(text_byte, CH_UP_B))
                        state_nxt.mode = MODE_BIN;
                    else if (is_letter(text_byte, CH_UP_D))
                        state_nxt.mode = MODE_DEC;
                    else if (is_letter(text_byte, CH_UP_A) && state_cur.mode == MODE_AMP)
                        state_nxt.mode = MODE_CHR;
                    else if (state_cur.mode == MODE_AMP &&
                             text_byte >= CH_ZERO && text_byte <= CH_SEVEN)
                    begin
                        // Bare ampersand followed by an octal digit.
                        state_nxt.acc  = VALUE_BITS'(text_byte[2:0]);
                        state_nxt.seen = 1'b1;
                        state_nxt.mode = MODE_OCT;
                    end
                    else
                    begin
                        state_nxt.mode = MODE_IDLE;
                        emit           = 1'b1;
                    end
                end
                MODE_HEX, MODE_OCT, MODE_BIN, MODE_DEC:
                begin
                    if (dig_ok)
                    begin
                        state_nxt.acc  = acc_scaled + VALUE_BITS'(dig[3:0]);
                        state_nxt.len  = len_inc;
                        state_nxt.seen = 1'b1;
                    end
                    else
                    begin
                        state_nxt.mode = MODE_IDLE;
                        emit           = 1'b1;
                        if (state_cur.seen)
                        begin
                            result.matched = 1'b1;
                            result.value   = 64'(state_cur.acc);
                            result.count   = 16'(state_cur.len);
                        end
                    end
                end
                MODE_CHR:
                begin
                    if (text_byte == CH_NUL)
                    begin
                        state_nxt.mode = MODE_IDLE;
                        emit           = 1'b1;
                    end
                    else
                    begin
                        state_nxt.len = len_inc;
                        if (text_byte == CH_DQUOTE || text_byte == CH_SQUOTE)
                        begin
                            state_nxt.quote = text_byte;
                            state_nxt.mode  = MODE_CHRQ;
                        end
                        else
                        begin
                            state_nxt.mode  = MODE_IDLE;
                            emit            = 1'b1;
                            result.matched  = 1'b1;
                            result.value    = 64'(text_byte);
                            result.count    = 16'(len_inc);
                            result.included = 1'b1;
                        end
                    end
                end
                MODE_CHRQ:
                begin
                    if (text_byte != CH_NUL && text_byte != state_cur.quote)
                    begin
                        state_nxt.acc  = VALUE_BITS'(text_byte);
                        state_nxt.seen = 1'b1;
                        state_nxt.len  = len_inc;
                        state_nxt.mode = MODE_CHRCLOSE;
                    end
                    else
                    begin
                        state_nxt.mode = MODE_IDLE;
                        emit           = 1'b1;
                    end
                end
                MODE_CHRCLOSE:
                begin
                    state_nxt.mode = MODE_IDLE;
                    emit           = 1'b1;
                    result.matched = 1'b1;
                    result.value   = 64'(state_cur.acc);
                    if (text_byte == state_cur.quote)
                    begin
                        result.count    = 16'(len_inc);
                        result.included = 1'b1;
                    end
                    else
                    begin
                        result.count = 16'(state_cur.len);
                    end
                end
                default:
                begin
                    // Idle, and any code that names no mode, waits quietly.
                    state_nxt.mode = MODE_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/radix_literal_scanner.sv =====
// Top level of the radix literal scanner: input stage, scan state and result register.
`default_nettype none

// Usage
// The slave side takes one text character per beat: s_tdata carries the byte, and
// s_tuser is set on the first character of a new candidate literal. A zero byte
// marks the end of the text. The master side gives at most one beat per candidate
// when the candidate resolves: matched flag, value (modulo 2^64, or the character
// code for the &A form), length including the prefix (saturating), and whether
// the byte that resolved it is part of the literal.
// A character accepted is held in the input stage and scanned there; its result,
// if any, is registered in the output register and shown on m_tvalid.
// Throughput: one character per cycle, sustained, unless a character that would
// give a second result must wait for a stalled output. The accumulate step is a
// constant shift-and-add on the 64-bit value, which sets the cycle budget.
// The block keeps accepting characters while a result waits in the output
// register; characters that give no result pass through even when the output is
// stalled. Only a character that would give a second result waits in the input stage
// until the receiver takes the first one, and then s_tready drops. Reset clears the
// input stage, the output register and the scan state (idle); no beat is lost or repeated across a stall.

module radix_literal_scanner (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tuser,   // [0] first
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata    // [0] matched, [64:1] literal_value,
                                        // [80:65] char_count, [81] byte_included,
                                        // [87:82] zero
);
    import rls_pkg::*;

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_first_reg;
    scan_state_t  state_reg;
    scan_state_t  state_next;
    logic         out_valid_reg;
    scan_result_t out_data_reg;

    logic         step_emit;
    scan_result_t step_result;
    logic         out_free;
    logic         advance;

    rls_step u_step (
        .text_byte (in_byte_reg),
        .first     (in_first_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .emit      (step_emit),
        .result    (step_result)
    );

    // The held character moves on when it gives no result or the result register
    // has room for its result.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!step_emit || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            state_reg.mode  <= MODE_IDLE;
            state_reg.acc   <= '0;
            state_reg.len   <= '0;
            state_reg.seen  <= 1'b0;
            state_reg.quote <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                state_reg <= state_next;
            if (advance && step_emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
        if (advance && step_emit)
            out_data_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule

`default_nettype wire
